// ===== hw/rtl/fspc_pkg.sv =====
`default_nettype none
package fspc_pkg;

   // Field widths
   localparam int NSAMP      = 5;
   localparam int SAMPLE_W   = 11;
   localparam int MASK_W     = 5;
   localparam int PED_W      = 10;
   localparam int BAND_W     = 10;
   localparam int MARGIN_W   = 10;
   localparam int RATIO_W    = 8;
   localparam int STATUS_W   = 3;
   localparam int FLAGS_W    = 20;
   localparam int POS_W      = 3;
   localparam int CNT_W      = 3;
   localparam int TICK_W     = 3;
   localparam int AMP_W      = 17;
   localparam int TIME_W     = 12;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 10;
   localparam int ADC_BITS_DEFAULT = 10;

   // Divider geometry
   localparam int DIV_N       = 24;
   localparam int DEN_W       = 12;
   localparam int DIV_STEPS   = 4;
   localparam int DIV_STAGES  = DIV_N / DIV_STEPS;
   localparam int SUM_W       = 25;

   // Saturation limits
   localparam logic signed [SUM_W-1:0] AMP_MIN  = -SUM_W'(65536);
   localparam logic signed [SUM_W-1:0] AMP_MAX  = SUM_W'(65535);
   localparam logic signed [SUM_W-1:0] TIME_MIN = -SUM_W'(2048);
   localparam logic signed [SUM_W-1:0] TIME_MAX = SUM_W'(2047);

   // Flag bit positions
   localparam int FLAG_BADAMP  = 0;
   localparam int FLAG_UNDER   = 1;
   localparam int FLAG_OVER    = 2;
   localparam int FLAG_SOMELT  = 3;
   localparam int FLAG_SOMEGT  = 4;
   localparam int FLAG_PED     = 5;
   localparam int FLAG_FIRSTLT = 6;
   localparam int FLAG_FIRSTGT = 7;
   localparam int FLAG_NOPEAK  = 8;
   localparam int FLAG_ONE     = 9;
   localparam int FLAG_TWO     = 10;
   localparam int FLAG_SAW     = 11;
   localparam int FLAG_SHLEFT  = 12;
   localparam int FLAG_TAIL    = 13;
   localparam int FLAG_RISE    = 14;
   localparam int FLAG_SPIKE   = 15;
   localparam int FLAG_TYPEDET = 16;
   localparam int FLAG_EST     = 17;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_PEDESTAL = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BAND     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MARGIN   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_RATIO    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE     = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      STATUS_EST      = 3'd0,
      STATUS_PED_RUN  = 3'd1,
      STATUS_NO_PED   = 3'd2,
      STATUS_BAD      = 3'd3,
      STATUS_PED_ONLY = 3'd4,
      STATUS_NO_PEAK  = 3'd5
   } status_type;

   typedef struct packed {
      logic [PED_W-1:0]    pedestal;
      logic [BAND_W-1:0]   band;
      logic [MARGIN_W-1:0] margin;
      logic [RATIO_W-1:0]  ratio;
      logic                mode;
   } cfg_type;

   typedef logic [NSAMP-1:0][SAMPLE_W-1:0] samples_type;

   // First stage: substituted samples and classification
   typedef struct packed {
      samples_type        a;
      logic [FLAGS_W-1:0] ty;
      logic [NSAMP-1:0]   pm;
      logic [POS_W-1:0]   pos;
      logic [CNT_W-1:0]   npk;
      logic [CNT_W-1:0]   nread;
      logic               first_read;
   } cls_type;

   // Second stage: chosen peak and neighbor extremes
   typedef struct packed {
      samples_type         a;
      logic [FLAGS_W-1:0]  ty;
      logic [NSAMP-1:0]    pm;
      logic [POS_W-1:0]    pos;
      logic [CNT_W-1:0]    nread;
      logic                first_read;
      logic [SAMPLE_W-1:0] smax;
      logic [SAMPLE_W-1:0] smin;
      logic                margin_ok;
   } sel_type;

   // Result fields carried alongside the division
   typedef struct packed {
      status_type               status;
      logic [FLAGS_W-1:0]       ty;
      logic [NSAMP-1:0]         pm;
      logic [POS_W-1:0]         pos;
      logic signed [AMP_W-1:0]  amp_base;
      logic signed [TIME_W-1:0] t_base;
      logic                     amp_neg;
      logic                     t_neg;
   } side_type;

   typedef struct packed {
      logic [DIV_N-1:0] num_a;
      logic [DIV_N-1:0] num_b;
      logic [DEN_W-1:0] den;
      side_type         side;
   } div_req_type;

   typedef struct packed {
      logic [DIV_N-1:0] q_a;
      logic [DIV_N-1:0] q_b;
      side_type         side;
   } div_rsp_type;

   localparam logic [TICK_W-1:0] TICK_TAB [2][NSAMP] = '{
      '{3'd0, 3'd1, 3'd2, 3'd3, 3'd4},
      '{3'd0, 3'd3, 3'd4, 3'd5, 3'd6}
   };

endpackage
`default_nettype wire

// ===== hw/rtl/fspc_if.sv =====
`default_nettype none
interface fspc_req_if;
   import fspc_pkg::*;
   logic                valid;
   logic                ready;
   logic [SAMPLE_W-1:0] sample_0;
   logic [SAMPLE_W-1:0] sample_1;
   logic [SAMPLE_W-1:0] sample_2;
   logic [SAMPLE_W-1:0] sample_3;
   logic [SAMPLE_W-1:0] sample_4;
   logic [MASK_W-1:0]   read_mask;

   modport source (output valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                   read_mask, input ready);
   modport sink (input valid, sample_0, sample_1, sample_2, sample_3, sample_4,
                 read_mask, output ready);
endinterface

interface fspc_rsp_if;
   import fspc_pkg::*;
   logic                     valid;
   logic                     ready;
   logic [STATUS_W-1:0]      status;
   logic [FLAGS_W-1:0]       type_flags;
   logic [NSAMP-1:0]         peak_mask;
   logic [POS_W-1:0]         peak_position;
   logic signed [AMP_W-1:0]  amplitude;
   logic signed [TIME_W-1:0] peak_time;

   modport source (output valid, status, type_flags, peak_mask, peak_position,
                   amplitude, peak_time, input ready);
   modport sink (input valid, status, type_flags, peak_mask, peak_position,
                 amplitude, peak_time, output ready);
endinterface
`default_nettype wire

// ===== hw/rtl/fspc_classify.sv =====
`default_nettype none
module fspc_classify #(
   parameter int ADC_BITS = fspc_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire fspc_pkg::cfg_type cfg,
   fspc_req_if.sink              req_chan,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output fspc_pkg::sel_type     out_data
);
   import fspc_pkg::*;

   localparam int CW = (ADC_BITS + 1 > SAMPLE_W) ? ADC_BITS + 1 : SAMPLE_W;
   localparam logic [CW-1:0] AMAX = CW'((1 << ADC_BITS) - 1);

   cls_type s1_ff, s1_in;
   sel_type s2_ff, s2_in;
   logic    v1_ff, v2_ff;
   logic    en1, en2;

   // Advance a stage when it is empty or its content moves on
   assign en2 = !v2_ff || out_ready;
   assign en1 = !v1_ff || en2;
   assign req_chan.ready = en1;
   assign out_valid = v2_ff;
   assign out_data  = s2_ff;

   // Stage one: substitute unread samples, classify against the band, find peaks
   always_comb begin
      logic [SAMPLE_W-1:0] raw [NSAMP];
      logic [SAMPLE_W:0]   up;
      logic [SAMPLE_W:0]   c12;
      logic [NSAMP-1:0]    gt;
      logic [NSAMP-1:0]    pk;
      logic [SAMPLE_W-1:0] bestv;
      logic                have;
      raw[0] = req_chan.sample_0;
      raw[1] = req_chan.sample_1;
      raw[2] = req_chan.sample_2;
      raw[3] = req_chan.sample_3;
      raw[4] = req_chan.sample_4;
      s1_in = '0;
      up = {2'b00, cfg.pedestal} + {2'b00, cfg.band};
      for (int i = 0; i < NSAMP; i++) begin
         s1_in.a[i] = req_chan.read_mask[i] ? raw[i] : {1'b0, cfg.pedestal};
      end
      for (int i = 0; i < NSAMP; i++) begin
         c12 = {1'b0, s1_in.a[i]};
         gt[i] = c12 > up;
         if (gt[i]) begin
            s1_in.ty[FLAG_SOMEGT] = 1'b1;
            if (cfg.mode && i == 0) s1_in.ty[FLAG_FIRSTGT] = 1'b1;
            if (CW'(s1_in.a[i]) == AMAX) s1_in.ty[FLAG_OVER] = 1'b1;
            else if (CW'(s1_in.a[i]) > AMAX) s1_in.ty[FLAG_BADAMP] = 1'b1;
         end else if ((c12 + {2'b00, cfg.band}) < {2'b00, cfg.pedestal}) begin
            s1_in.ty[FLAG_SOMELT] = 1'b1;
            if (cfg.mode && i == 0) s1_in.ty[FLAG_FIRSTLT] = 1'b1;
            if (s1_in.a[i] == '0) s1_in.ty[FLAG_UNDER] = 1'b1;
         end
      end
      if (!s1_in.ty[FLAG_SOMEGT] && !s1_in.ty[FLAG_SOMELT]) s1_in.ty[FLAG_PED] = 1'b1;
      // local peaks: above the band, rising from the left, not rising to the right
      pk = gt;
      for (int i = 1; i < NSAMP; i++) begin
         if (!(s1_in.a[i] > s1_in.a[i-1])) pk[i] = 1'b0;
      end
      for (int i = 0; i < NSAMP - 1; i++) begin
         if (!(s1_in.a[i] >= s1_in.a[i+1])) pk[i] = 1'b0;
      end
      s1_in.pm = pk;
      // pick the earliest highest peak
      bestv = '0;
      have  = 1'b0;
      for (int i = 0; i < NSAMP; i++) begin
         if (pk[i] && (!have || s1_in.a[i] > bestv)) begin
            bestv = s1_in.a[i];
            s1_in.pos = POS_W'(i);
            have = 1'b1;
         end
      end
      s1_in.npk = CNT_W'($countones(pk));
      s1_in.nread = CNT_W'($countones(req_chan.read_mask));
      s1_in.first_read = req_chan.read_mask[0];
   end

   // Stage two: settle the peak position, shape flags and neighbor extremes
   always_comb begin
      logic [POS_W-1:0]    pos;
      logic [SAMPLE_W:0]   lim;
      s2_in = '0;
      s2_in.a          = s1_ff.a;
      s2_in.pm         = s1_ff.pm;
      s2_in.nread      = s1_ff.nread;
      s2_in.first_read = s1_ff.first_read;
      s2_in.ty         = s1_ff.ty;
      pos = s1_ff.pos;
      if (s1_ff.npk == '0) begin
         s2_in.ty[FLAG_NOPEAK] = 1'b1;
      end else begin
         if (s1_ff.npk == CNT_W'(1)) s2_in.ty[FLAG_ONE] = 1'b1;
         else if (s1_ff.npk == CNT_W'(2)) s2_in.ty[FLAG_TWO] = 1'b1;
         else if (s1_ff.npk == CNT_W'(3)) s2_in.ty[FLAG_SAW] = 1'b1;
         if (pos == POS_W'(0)) begin
            if (s1_ff.a[0] == s1_ff.a[1]) pos = POS_W'(1);
            else s2_in.ty[FLAG_TAIL] = 1'b1;
         end
         if (cfg.mode && pos == POS_W'(1)) begin
            if (s1_ff.a[1] == s1_ff.a[2]) pos = POS_W'(2);
            else s2_in.ty[FLAG_SHLEFT] = 1'b1;
         end
         if (pos == POS_W'(NSAMP - 1)) s2_in.ty[FLAG_RISE] = 1'b1;
      end
      s2_in.ty[FLAG_TYPEDET] = 1'b1;
      s2_in.pos = pos;
      s2_in.smax = '0;
      s2_in.smin = '1;
      for (int i = 0; i < NSAMP; i++) begin
         if (POS_W'(i) != pos) begin
            if (s2_in.smax < s1_ff.a[i]) s2_in.smax = s1_ff.a[i];
            if (s2_in.smin > s1_ff.a[i]) s2_in.smin = s1_ff.a[i];
         end
      end
      lim = {1'b0, s2_in.smax} + {2'b00, cfg.margin};
      s2_in.margin_ok = {1'b0, s1_ff.a[pos]} > lim;
   end

   // Hold or advance the stage registers
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         if (en1) v1_ff <= req_chan.valid;
         if (en2) v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en1) s1_ff <= s1_in;
      if (en2) s2_ff <= s2_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/fspc_prep.sv =====
`default_nettype none
module fspc_prep (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire fspc_pkg::cfg_type  cfg,
   input  wire logic               in_valid,
   output logic                    in_ready,
   input  wire fspc_pkg::sel_type  in_data,
   output logic                    out_valid,
   input  wire logic               out_ready,
   output fspc_pkg::div_req_type   out_data
);
   import fspc_pkg::*;

   div_req_type s3_ff, s3_in;
   logic        v3_ff;

   assign in_ready  = !v3_ff || out_ready;
   assign out_valid = v3_ff;
   assign out_data  = s3_ff;

   // Spike test, status, interpolation terms and division operands
   always_comb begin
      logic [SAMPLE_W-1:0]        apk;
      logic [SAMPLE_W-1:0]        am;
      logic [SAMPLE_W-1:0]        ap;
      logic [SAMPLE_W-1:0]        avg;
      logic signed [SAMPLE_W+1:0] dpk;
      logic signed [20:0]         lhs;
      logic signed [20:0]         rhs;
      logic [FLAGS_W-1:0]         ty;
      logic signed [13:0]         cc;
      logic signed [11:0]         dd;
      logic [13:0]                c_mag;
      logic [11:0]                d_mag;
      logic [21:0]                d_sq;
      logic                       use_i;
      logic signed [12:0]         pdiff;
      apk = in_data.a[in_data.pos];
      avg = SAMPLE_W'(({1'b0, in_data.smax} + {1'b0, in_data.smin}) >> 1);
      dpk = $signed({2'b00, apk}) - $signed({2'b00, avg});
      lhs = 21'(dpk) <<< 4;
      rhs = $signed({2'b00, 19'(cfg.ratio) * 19'(in_data.smax - in_data.smin)});
      ty = in_data.ty;
      if (!cfg.mode && !ty[FLAG_NOPEAK] && in_data.margin_ok && lhs > rhs)
         ty[FLAG_SPIKE] = 1'b1;

      // neighbors of the chosen sample
      am = '0;
      ap = '0;
      unique case (in_data.pos)
         POS_W'(1): begin am = in_data.a[0]; ap = in_data.a[2]; end
         POS_W'(2): begin am = in_data.a[1]; ap = in_data.a[3]; end
         POS_W'(3): begin am = in_data.a[2]; ap = in_data.a[4]; end
         default:   begin am = '0; ap = '0; end
      endcase
      cc = $signed({2'b00, apk, 1'b0}) - $signed({3'b000, am}) - $signed({3'b000, ap});
      dd = $signed({1'b0, ap}) - $signed({1'b0, am});
      c_mag = cc[13] ? 14'(-cc) : 14'(cc);
      d_mag = dd[11] ? 12'(-dd) : 12'(dd);
      d_sq = d_mag[10:0] * d_mag[10:0];

      s3_in = '0;
      s3_in.side.pm  = in_data.pm;
      s3_in.side.pos = in_data.pos;
      s3_in.side.ty  = ty;
      use_i = 1'b0;
      pdiff = $signed({2'b00, apk}) - $signed({3'b000, cfg.pedestal});
      priority if (cfg.pedestal == '0) begin
         s3_in.side = '0;
         if (in_data.first_read) begin
            s3_in.side.status = STATUS_PED_RUN;
            s3_in.side.ty[FLAG_PED] = 1'b1;
         end else begin
            s3_in.side.status = STATUS_NO_PED;
         end
      end else if (ty[FLAG_BADAMP] || ty[FLAG_UNDER]) begin
         s3_in.side.status = STATUS_BAD;
      end else if (ty[FLAG_PED]) begin
         s3_in.side.status = STATUS_PED_ONLY;
      end else if (ty[FLAG_NOPEAK]) begin
         s3_in.side.status = STATUS_NO_PEAK;
      end else begin
         s3_in.side.status = STATUS_EST;
         s3_in.side.ty[FLAG_EST] = 1'b1;
         s3_in.side.amp_base = {pdiff, 4'b0000};
         s3_in.side.t_base = {1'b0, TICK_TAB[cfg.mode][in_data.pos], 8'h00};
         use_i = (in_data.nread != CNT_W'(1)) && !ty[FLAG_RISE] && !ty[FLAG_TAIL]
                 && !ty[FLAG_SHLEFT] && (in_data.pos >= POS_W'(1))
                 && (in_data.pos <= POS_W'(3)) && (cc != '0);
      end
      s3_in.side.amp_neg = cc[13];
      s3_in.side.t_neg   = cc[13] ^ dd[11];
      s3_in.num_a = use_i ? {1'b0, d_sq, 1'b0} : '0;
      s3_in.num_b = use_i ? {6'd0, d_mag[10:0], 7'd0} : '0;
      s3_in.den   = use_i ? c_mag[DEN_W-1:0] : DEN_W'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v3_ff <= 1'b0;
      end else if (in_ready) begin
         v3_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (in_ready) s3_ff <= s3_in;
   end

endmodule
`default_nettype wire

// ===== hw/rtl/fspc_div.sv =====
`default_nettype none
module fspc_div (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  in_valid,
   output logic                       in_ready,
   input  wire fspc_pkg::div_req_type in_data,
   output logic                       out_valid,
   input  wire logic                  out_ready,
   output fspc_pkg::div_rsp_type      out_data
);
   import fspc_pkg::*;

   typedef struct packed {
      logic [DEN_W-1:0] rem_a;
      logic [DIV_N-1:0] num_a;
      logic [DEN_W-1:0] rem_b;
      logic [DIV_N-1:0] num_b;
      logic [DEN_W-1:0] den;
      side_type         side;
   } div_stage_type;

   typedef struct packed {
      logic [DEN_W-1:0] rem;
      logic [DIV_N-1:0] num;
   } rn_type;

   // One restoring step: shift in the next dividend bit, subtract when it fits
   function automatic rn_type div_step(input rn_type x, input logic [DEN_W-1:0] den);
      rn_type     r;
      logic [DEN_W:0] t;
      t = {x.rem, x.num[DIV_N-1]};
      r.num = {x.num[DIV_N-2:0], 1'b0};
      if (t >= {1'b0, den}) begin
         t = t - {1'b0, den};
         r.num[0] = 1'b1;
      end
      r.rem = t[DEN_W-1:0];
      return r;
   endfunction

   div_stage_type st_ff [DIV_STAGES];
   div_stage_type st_in [DIV_STAGES];
   div_stage_type src   [DIV_STAGES];
   logic [DIV_STAGES-1:0] v_ff;
   logic [DIV_STAGES:0]   en;

   assign en[DIV_STAGES] = out_ready;
   assign in_ready  = en[0];
   assign out_valid = v_ff[DIV_STAGES-1];
   assign out_data.q_a  = st_ff[DIV_STAGES-1].num_a;
   assign out_data.q_b  = st_ff[DIV_STAGES-1].num_b;
   assign out_data.side = st_ff[DIV_STAGES-1].side;

   for (genvar k = 0; k < DIV_STAGES; k++) begin : g_stage
      assign en[k] = !v_ff[k] || en[k+1];

      if (k == 0) begin : g_first
         always_comb begin
            src[k].rem_a = '0;
            src[k].num_a = in_data.num_a;
            src[k].rem_b = '0;
            src[k].num_b = in_data.num_b;
            src[k].den   = in_data.den;
            src[k].side  = in_data.side;
         end
         always_ff @(posedge clock) begin
            if (reset) v_ff[k] <= 1'b0;
            else if (en[k]) v_ff[k] <= in_valid;
         end
      end else begin : g_next
         assign src[k] = st_ff[k-1];
         always_ff @(posedge clock) begin
            if (reset) v_ff[k] <= 1'b0;
            else if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end

      // Run DIV_STEPS quotient bits per stage for both dividends
      always_comb begin
         rn_type ra;
         rn_type rb;
         ra.rem = src[k].rem_a;
         ra.num = src[k].num_a;
         rb.rem = src[k].rem_b;
         rb.num = src[k].num_b;
         for (int s = 0; s < DIV_STEPS; s++) begin
            ra = div_step(ra, src[k].den);
            rb = div_step(rb, src[k].den);
         end
         st_in[k].rem_a = ra.rem;
         st_in[k].num_a = ra.num;
         st_in[k].rem_b = rb.rem;
         st_in[k].num_b = rb.num;
         st_in[k].den   = src[k].den;
         st_in[k].side  = src[k].side;
      end

      always_ff @(posedge clock) begin
         if (en[k]) st_ff[k] <= st_in[k];
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/five_sample_pulse_classifier.sv =====
`default_nettype none
// Five-sample pulse classifier.
// req_chan carries one hit per transaction: five ADC samples and the read mask.
// rsp_chan returns one result per hit, in order: status, classification flags,
// peak mask and position, amplitude (signed Q.4) and peak time (signed Q.8).
// csr_we/csr_index/csr_wdata write the pedestal, band, spike margin, spike ratio
// and sample mode registers; write them only while no hit is in flight.
// An accepted hit passes two classification stages, one stage for the spike test
// and interpolation operands, six stages of a restoring divider resolving four
// quotient bits each, and the output register. A new hit is taken every cycle
// unless a stalled receiver has filled the pipeline.
// Every stage has its own valid bit and loads whenever it is empty or its
// content moves on, so a stalled receiver fills the pipe without losing or
// repeating a transaction, and bubbles close up while the output waits.
// Synchronous reset empties the pipeline and loads the register defaults
// (pedestal 0, band 3, margin 3, ratio 40, mode 0).
module five_sample_pulse_classifier #(
   parameter int ADC_BITS = fspc_pkg::ADC_BITS_DEFAULT
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   fspc_req_if.sink                             req_chan,
   fspc_rsp_if.source                           rsp_chan,
   input  wire logic                            csr_we,
   input  wire logic [fspc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [fspc_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import fspc_pkg::*;

   cfg_type     cfg_ff;
   sel_type     sel_data;
   div_req_type prep_data;
   div_rsp_type div_data;
   logic        sel_valid, sel_ready;
   logic        prep_valid, prep_ready;
   logic        div_valid, div_ready;
   logic        out_valid_ff;
   logic [STATUS_W-1:0]      status_ff;
   logic [FLAGS_W-1:0]       flags_ff;
   logic [NSAMP-1:0]         pm_ff;
   logic [POS_W-1:0]         pos_ff;
   logic signed [AMP_W-1:0]  amp_ff, amp_in;
   logic signed [TIME_W-1:0] time_ff, time_in;

   // Write configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.pedestal <= '0;
         cfg_ff.band     <= BAND_W'(3);
         cfg_ff.margin   <= MARGIN_W'(3);
         cfg_ff.ratio    <= RATIO_W'(40);
         cfg_ff.mode     <= 1'b0;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_PEDESTAL: cfg_ff.pedestal <= csr_wdata[PED_W-1:0];
            CSR_BAND:     cfg_ff.band     <= csr_wdata[BAND_W-1:0];
            CSR_MARGIN:   cfg_ff.margin   <= csr_wdata[MARGIN_W-1:0];
            CSR_RATIO:    cfg_ff.ratio    <= csr_wdata[RATIO_W-1:0];
            CSR_MODE:     cfg_ff.mode     <= csr_wdata[0];
            default:      cfg_ff          <= cfg_ff;
         endcase
      end
   end

   fspc_classify #(.ADC_BITS(ADC_BITS)) u_classify (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .req_chan  (req_chan),
      .out_valid (sel_valid),
      .out_ready (sel_ready),
      .out_data  (sel_data)
   );

   fspc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (sel_valid),
      .in_ready  (sel_ready),
      .in_data   (sel_data),
      .out_valid (prep_valid),
      .out_ready (prep_ready),
      .out_data  (prep_data)
   );

   fspc_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (prep_valid),
      .in_ready  (prep_ready),
      .in_data   (prep_data),
      .out_valid (div_valid),
      .out_ready (div_ready),
      .out_data  (div_data)
   );

   // Apply the signed corrections and saturate
   always_comb begin
      logic signed [SUM_W-1:0] qa;
      logic signed [SUM_W-1:0] qb;
      logic signed [SUM_W-1:0] asum;
      logic signed [SUM_W-1:0] tsum;
      qa = $signed({1'b0, div_data.q_a});
      qb = $signed({1'b0, div_data.q_b});
      asum = SUM_W'(div_data.side.amp_base) + (div_data.side.amp_neg ? -qa : qa);
      tsum = SUM_W'(div_data.side.t_base) + (div_data.side.t_neg ? -qb : qb);
      if (asum < AMP_MIN) asum = AMP_MIN;
      else if (asum > AMP_MAX) asum = AMP_MAX;
      if (tsum < TIME_MIN) tsum = TIME_MIN;
      else if (tsum > TIME_MAX) tsum = TIME_MAX;
      amp_in  = asum[AMP_W-1:0];
      time_in = tsum[TIME_W-1:0];
   end

   // Output register: hold while the receiver stalls
   assign div_ready = !out_valid_ff || rsp_chan.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (div_ready) begin
         out_valid_ff <= div_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (div_ready) begin
         status_ff <= div_data.side.status;
         flags_ff  <= div_data.side.ty;
         pm_ff     <= div_data.side.pm;
         pos_ff    <= div_data.side.pos;
         amp_ff    <= amp_in;
         time_ff   <= time_in;
      end
   end

   assign rsp_chan.valid         = out_valid_ff;
   assign rsp_chan.status        = status_ff;
   assign rsp_chan.type_flags    = flags_ff;
   assign rsp_chan.peak_mask     = pm_ff;
   assign rsp_chan.peak_position = pos_ff;
   assign rsp_chan.amplitude     = amp_ff;
   assign rsp_chan.peak_time     = time_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/fspc_checker.sv =====
`default_nettype none
module fspc_checker (
   input wire logic                                 clock,
   input wire logic                                 reset,
   input wire logic                                 rsp_valid,
   input wire logic                                 rsp_ready,
   input wire logic [fspc_pkg::STATUS_W-1:0]        rsp_status,
   input wire logic [fspc_pkg::FLAGS_W-1:0]         rsp_flags,
   input wire logic signed [fspc_pkg::AMP_W-1:0]    rsp_amp,
   input wire logic signed [fspc_pkg::TIME_W-1:0]   rsp_time
);
   import fspc_pkg::*;

   // A stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_flags) && $stable(rsp_amp) && $stable(rsp_time))
      else $error("stalled result changed");

   // Only estimated results carry amplitude and time
   a_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_EST |-> rsp_amp == '0 && rsp_time == '0)
      else $error("non-estimated result with amplitude or time");

   // Estimated results carry the estimated and type-determined flags
   a_est: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == STATUS_EST |->
         rsp_flags[FLAG_EST] && rsp_flags[FLAG_TYPEDET] && !rsp_flags[FLAG_NOPEAK])
      else $error("estimated result missing flags");

   // Undefined pedestal gives an empty flag word; fit flags never set
   a_noped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_status != STATUS_NO_PED || rsp_flags == '0)
         && !rsp_flags[18] && !rsp_flags[19])
      else $error("bad flag word");

endmodule

bind five_sample_pulse_classifier fspc_checker u_fspc_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_valid  (rsp_chan.valid),
   .rsp_ready  (rsp_chan.ready),
   .rsp_status (rsp_chan.status),
   .rsp_flags  (rsp_chan.type_flags),
   .rsp_amp    (rsp_chan.amplitude),
   .rsp_time   (rsp_chan.peak_time)
);
`default_nettype wire
